// File: src/mmh_pkg.sv
`default_nettype none
package mmh_pkg;

   localparam int DEF_CAPACITY  = 256;
   localparam int DEF_KEY_WIDTH = 32;
   localparam int KEY_BITS      = 32;
   localparam int OP_BITS       = 2;
   localparam int STATUS_BITS   = 2;
   localparam int REQ_BITS      = 40;

   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_REMOVE_MIN = 2'd1,
      OP_REMOVE_MAX = 2'd2,
      OP_REMOVE_KEY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MAX_RD1,
      ST_MAX_RD2,
      ST_MAX_CMP,
      ST_TAKE_RD,
      ST_TAKE_LAST,
      ST_TAKE_GET,
      ST_SCAN,
      ST_KEY_GET,
      ST_BUB_START,
      ST_BUB_PCMP,
      ST_CLB_RD,
      ST_CLB_CMP,
      ST_BUB_END,
      ST_BUB_REREAD,
      ST_SNK_START,
      ST_SNK_SCAN,
      ST_SNK_DEC,
      ST_SNK_W2,
      ST_FIN0,
      ST_FIN1,
      ST_FIN2,
      ST_FIN3,
      ST_OUT
   } state_type;

   // n is index plus one; min level when the top set bit sits at an even position
   function automatic logic min_level(input logic [31:0] n);
      logic par;
      par = 1'b0;
      for (int b = 0; b < 32; b++) begin
         if (n[b]) begin
            par = b[0];
         end
      end
      return !par;
   endfunction

endpackage
`default_nettype wire

// File: src/mmh_ram.sv
`default_nettype none
module mmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: src/min_max_heap_unit.sv
`default_nettype none
// min-max heap, one request in flight, one result word per request word
// insert sifts the new entry up; remove min or max takes that entry, moves the last entry into
// its place and sifts it down; remove by key scans the entries in order until it finds the key, then sifts
// the next request is accepted from the cycle after the result register loads
// heap ram has one read and one write port
// synchronous reset empties the heap; ram contents are not cleared
module min_max_heap_unit #(
   parameter int CAPACITY  = mmh_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = mmh_pkg::DEF_KEY_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [mmh_pkg::REQ_BITS-1:0] req_tdata, // op, key
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status, removed_key, entry_count, min_key, max_key
   output logic [((98 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = IW + 3;
   localparam int SW = (KEY_WIDTH < mmh_pkg::KEY_BITS) ? KEY_WIDTH : mmh_pkg::KEY_BITS;
   localparam int RW = ((98 + CW + 7) / 8) * 8;

   mmh_pkg::state_type  state_ff, state_in;
   mmh_pkg::op_type     op_ff, op_in;
   mmh_pkg::status_type stat_ff, stat_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] key_ff, key_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] c_ff, c_in;
   logic [SW-1:0] tmp_ff, tmp_in;
   logic [SW-1:0] best_ff, best_in;
   logic [SW-1:0] ch0_ff, ch0_in;
   logic [SW-1:0] ch1_ff, ch1_in;
   logic [SW-1:0] mn_ff, mn_in;
   logic [SW-1:0] w2_data_ff, w2_data_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] orig_ff, orig_in;
   logic [IW-1:0] w2_addr_ff, w2_addr_in;
   logic          w2_fin_ff, w2_fin_in;
   logic          climb_min_ff, climb_min_in;
   logic          sink_min_ff, sink_min_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          chk_ff, chk_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;
   logic [2:0]    a_ff, a_in;
   logic [2:0]    k_ff, k_in;
   logic [2:0]    bk_ff, bk_in;

   logic                    o_valid_ff, o_valid_in;
   mmh_pkg::status_type     o_stat_ff, o_stat_in;
   logic [SW-1:0]           o_rem_ff, o_rem_in;
   logic [CW-1:0]           o_cnt_ff, o_cnt_in;
   logic [SW-1:0]           o_mn_ff, o_mn_in;
   logic [SW-1:0]           o_mx_ff, o_mx_in;

   logic          we, re;
   logic [IW-1:0] waddr, raddr;
   logic [SW-1:0] wdata, rdata;

   mmh_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_en   (re),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   // tree geometry around the current index
   logic [XW-1:0] ix, c1x, gx, nx, cnt_dec_x;
   logic [IW-1:0] par_i, gpar_i;
   logic          lvl_min;
   logic [2:0]    below;
   logic [XW-1:0] diff;

   assign ix        = XW'(i_ff);
   assign c1x       = (ix << 1) + XW'(1);
   assign gx        = (ix << 2) + XW'(3);
   assign nx        = XW'(cnt_ff);
   assign cnt_dec_x = XW'(cnt_ff) - XW'(1);
   assign par_i     = (i_ff - IW'(1)) >> 1;
   assign gpar_i    = (par_i - IW'(1)) >> 1;
   assign lvl_min   = mmh_pkg::min_level(32'(i_ff) + 32'd1);

   always_comb begin
      diff  = '0;
      below = 3'd0;
      if (nx <= c1x) begin
         below = 3'd0;
      end else if (nx <= gx) begin
         diff  = nx - c1x;
         below = (diff >= XW'(2)) ? 3'd2 : diff[2:0];
      end else begin
         diff  = nx - gx + XW'(2);
         below = (diff >= XW'(6)) ? 3'd6 : diff[2:0];
      end
   end

   function automatic logic [XW-1:0] cand(input logic [2:0] k, input logic [XW-1:0] c1,
                                          input logic [XW-1:0] g);
      logic [XW-1:0] r;
      if (k == 3'd0) begin
         r = c1;
      end else if (k == 3'd1) begin
         r = c1 + XW'(1);
      end else begin
         r = g + XW'(k) - XW'(2);
      end
      return r;
   endfunction

   logic [2:0]    rk;
   logic          better_rd;
   logic [XW-1:0] bidx_x, pidx_x, kidx_x;
   logic [SW-1:0] pval;
   logic          best_beats_c, c_beyond_p;

   assign rk        = k_ff - 3'd1;
   assign better_rd = sink_min_ff ? (rdata < best_ff) : (rdata > best_ff);
   assign bidx_x    = cand(bk_ff, c1x, gx);
   assign kidx_x    = cand(k_ff, c1x, gx);
   assign pidx_x    = (bk_ff < 3'd4) ? c1x : c1x + XW'(1);
   assign pval      = (bk_ff < 3'd4) ? ch0_ff : ch1_ff;
   assign best_beats_c = sink_min_ff ? (best_ff < c_ff) : (best_ff > c_ff);
   assign c_beyond_p   = sink_min_ff ? (c_ff > pval) : (c_ff < pval);

   logic          req_acc;
   logic [SW-1:0] req_key;
   logic [1:0]    req_op;

   assign req_tready = (state_ff == mmh_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_op     = req_tdata[1:0];
   assign req_key    = SW'(req_tdata[mmh_pkg::KEY_BITS + 1:2]);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      stat_in      = stat_ff;
      cnt_in       = cnt_ff;
      key_in       = key_ff;
      rem_in       = rem_ff;
      c_in         = c_ff;
      tmp_in       = tmp_ff;
      best_in      = best_ff;
      ch0_in       = ch0_ff;
      ch1_in       = ch1_ff;
      mn_in        = mn_ff;
      w2_data_in   = w2_data_ff;
      i_in         = i_ff;
      orig_in      = orig_ff;
      w2_addr_in   = w2_addr_ff;
      w2_fin_in    = w2_fin_ff;
      climb_min_in = climb_min_ff;
      sink_min_in  = sink_min_ff;
      scan_in      = scan_ff;
      chk_in       = chk_ff;
      chk_idx_in   = chk_idx_ff;
      a_in         = a_ff;
      k_in         = k_ff;
      bk_in        = bk_ff;
      o_valid_in   = o_valid_ff;
      o_stat_in    = o_stat_ff;
      o_rem_in     = o_rem_ff;
      o_cnt_in     = o_cnt_ff;
      o_mn_in      = o_mn_ff;
      o_mx_in      = o_mx_ff;
      we           = 1'b0;
      waddr        = '0;
      wdata        = '0;
      re           = 1'b0;
      raddr        = '0;

      if (o_valid_ff && rsp_tready) begin
         o_valid_in = 1'b0;
      end

      unique case (state_ff)
         mmh_pkg::ST_IDLE: begin
            if (req_acc) begin
               op_in   = mmh_pkg::op_type'(req_op);
               key_in  = req_key;
               stat_in = mmh_pkg::STAT_OK;
               rem_in  = '0;
               scan_in = '0;
               chk_in  = 1'b0;
               if (mmh_pkg::op_type'(req_op) == mmh_pkg::OP_INSERT) begin
                  if (cnt_ff >= CW'(CAPACITY)) begin
                     stat_in  = mmh_pkg::STAT_FULL;
                     state_in = mmh_pkg::ST_FIN0;
                  end else begin
                     i_in     = cnt_ff[IW-1:0];
                     c_in     = req_key;
                     cnt_in   = cnt_ff + CW'(1);
                     state_in = mmh_pkg::ST_BUB_START;
                  end
               end else if (cnt_ff == '0) begin
                  stat_in  = mmh_pkg::STAT_EMPTY;
                  state_in = mmh_pkg::ST_FIN0;
               end else if (mmh_pkg::op_type'(req_op) == mmh_pkg::OP_REMOVE_KEY) begin
                  state_in = mmh_pkg::ST_SCAN;
               end else if (mmh_pkg::op_type'(req_op) == mmh_pkg::OP_REMOVE_MIN ||
                            cnt_ff == CW'(1)) begin
                  i_in        = '0;
                  sink_min_in = 1'b1;
                  state_in    = mmh_pkg::ST_TAKE_RD;
               end else if (cnt_ff == CW'(2)) begin
                  i_in        = IW'(1);
                  sink_min_in = 1'b0;
                  state_in    = mmh_pkg::ST_TAKE_RD;
               end else begin
                  sink_min_in = 1'b0;
                  state_in    = mmh_pkg::ST_MAX_RD1;
               end
            end
         end
         mmh_pkg::ST_MAX_RD1: begin
            re       = 1'b1;
            raddr    = IW'(1);
            state_in = mmh_pkg::ST_MAX_RD2;
         end
         mmh_pkg::ST_MAX_RD2: begin
            re       = 1'b1;
            raddr    = IW'(2);
            tmp_in   = rdata;
            state_in = mmh_pkg::ST_MAX_CMP;
         end
         mmh_pkg::ST_MAX_CMP: begin
            i_in     = (tmp_ff > rdata) ? IW'(1) : IW'(2);
            state_in = mmh_pkg::ST_TAKE_RD;
         end
         mmh_pkg::ST_TAKE_RD: begin
            re       = 1'b1;
            raddr    = i_ff;
            state_in = mmh_pkg::ST_TAKE_LAST;
         end
         mmh_pkg::ST_TAKE_LAST: begin
            rem_in = rdata;
            cnt_in = cnt_ff - CW'(1);
            if (ix < cnt_dec_x) begin
               re       = 1'b1;
               raddr    = cnt_dec_x[IW-1:0];
               state_in = mmh_pkg::ST_TAKE_GET;
            end else begin
               state_in = mmh_pkg::ST_FIN0;
            end
         end
         mmh_pkg::ST_TAKE_GET: begin
            c_in     = rdata;
            state_in = mmh_pkg::ST_SNK_START;
         end
         mmh_pkg::ST_SCAN: begin
            if (chk_ff && rdata == key_ff) begin
               rem_in = rdata;
               cnt_in = cnt_ff - CW'(1);
               i_in   = chk_idx_ff;
               if (XW'(chk_idx_ff) == cnt_dec_x) begin
                  state_in = mmh_pkg::ST_FIN0;
               end else begin
                  re       = 1'b1;
                  raddr    = cnt_dec_x[IW-1:0];
                  state_in = mmh_pkg::ST_KEY_GET;
               end
            end else if (scan_ff < cnt_ff) begin
               re         = 1'b1;
               raddr      = scan_ff[IW-1:0];
               chk_in     = 1'b1;
               chk_idx_in = scan_ff[IW-1:0];
               scan_in    = scan_ff + CW'(1);
            end else begin
               stat_in  = mmh_pkg::STAT_NOT_FOUND;
               state_in = mmh_pkg::ST_FIN0;
            end
         end
         mmh_pkg::ST_KEY_GET: begin
            c_in     = rdata;
            orig_in  = i_ff;
            state_in = mmh_pkg::ST_BUB_START;
         end
         mmh_pkg::ST_BUB_START: begin
            if (i_ff == '0) begin
               we       = 1'b1;
               waddr    = i_ff;
               wdata    = c_ff;
               state_in = mmh_pkg::ST_BUB_END;
            end else begin
               re       = 1'b1;
               raddr    = par_i;
               state_in = mmh_pkg::ST_BUB_PCMP;
            end
         end
         mmh_pkg::ST_BUB_PCMP: begin
            if (lvl_min ? (c_ff > rdata) : (c_ff < rdata)) begin
               we           = 1'b1;
               waddr        = i_ff;
               wdata        = rdata;
               i_in         = par_i;
               climb_min_in = !lvl_min;
            end else begin
               climb_min_in = lvl_min;
            end
            state_in = mmh_pkg::ST_CLB_RD;
         end
         mmh_pkg::ST_CLB_RD: begin
            if (climb_min_ff ? (i_ff > IW'(2)) : (XW'(i_ff) > XW'(6))) begin
               re       = 1'b1;
               raddr    = gpar_i;
               state_in = mmh_pkg::ST_CLB_CMP;
            end else begin
               we       = 1'b1;
               waddr    = i_ff;
               wdata    = c_ff;
               state_in = mmh_pkg::ST_BUB_END;
            end
         end
         mmh_pkg::ST_CLB_CMP: begin
            if (climb_min_ff ? (c_ff < rdata) : (c_ff > rdata)) begin
               we       = 1'b1;
               waddr    = i_ff;
               wdata    = rdata;
               i_in     = gpar_i;
               state_in = mmh_pkg::ST_CLB_RD;
            end else begin
               we       = 1'b1;
               waddr    = i_ff;
               wdata    = c_ff;
               state_in = mmh_pkg::ST_BUB_END;
            end
         end
         mmh_pkg::ST_BUB_END: begin
            if (op_ff == mmh_pkg::OP_INSERT) begin
               state_in = mmh_pkg::ST_FIN0;
            end else begin
               re       = 1'b1;
               raddr    = orig_ff;
               i_in     = orig_ff;
               state_in = mmh_pkg::ST_BUB_REREAD;
            end
         end
         mmh_pkg::ST_BUB_REREAD: begin
            c_in        = rdata;
            sink_min_in = lvl_min;
            state_in    = mmh_pkg::ST_SNK_START;
         end
         mmh_pkg::ST_SNK_START: begin
            a_in = below;
            if (below == 3'd0) begin
               we       = 1'b1;
               waddr    = i_ff;
               wdata    = c_ff;
               state_in = mmh_pkg::ST_FIN0;
            end else begin
               re       = 1'b1;
               raddr    = c1x[IW-1:0];
               k_in     = 3'd1;
               state_in = mmh_pkg::ST_SNK_SCAN;
            end
         end
         mmh_pkg::ST_SNK_SCAN: begin
            if (rk == 3'd0) begin
               best_in = rdata;
               bk_in   = 3'd0;
               ch0_in  = rdata;
            end else begin
               if (rk == 3'd1) begin
                  ch1_in = rdata;
               end
               if (better_rd) begin
                  best_in = rdata;
                  bk_in   = rk;
               end
            end
            if (k_ff < a_ff) begin
               re    = 1'b1;
               raddr = kidx_x[IW-1:0];
               k_in  = k_ff + 3'd1;
            end else begin
               state_in = mmh_pkg::ST_SNK_DEC;
            end
         end
         mmh_pkg::ST_SNK_DEC: begin
            we    = 1'b1;
            waddr = i_ff;
            if (!best_beats_c) begin
               wdata    = c_ff;
               state_in = mmh_pkg::ST_FIN0;
            end else if (bk_ff >= 3'd2) begin
               wdata = best_ff;
               i_in  = bidx_x[IW-1:0];
               if (c_beyond_p) begin
                  w2_addr_in = pidx_x[IW-1:0];
                  w2_data_in = c_ff;
                  w2_fin_in  = 1'b0;
                  c_in       = pval;
                  state_in   = mmh_pkg::ST_SNK_W2;
               end else begin
                  state_in = mmh_pkg::ST_SNK_START;
               end
            end else begin
               wdata      = best_ff;
               w2_addr_in = bidx_x[IW-1:0];
               w2_data_in = c_ff;
               w2_fin_in  = 1'b1;
               state_in   = mmh_pkg::ST_SNK_W2;
            end
         end
         mmh_pkg::ST_SNK_W2: begin
            we       = 1'b1;
            waddr    = w2_addr_ff;
            wdata    = w2_data_ff;
            state_in = w2_fin_ff ? mmh_pkg::ST_FIN0 : mmh_pkg::ST_SNK_START;
         end
         mmh_pkg::ST_FIN0: begin
            if (cnt_ff == '0) begin
               mn_in    = '0;
               tmp_in   = '0;
               state_in = mmh_pkg::ST_OUT;
            end else begin
               re       = 1'b1;
               raddr    = '0;
               state_in = mmh_pkg::ST_FIN1;
            end
         end
         mmh_pkg::ST_FIN1: begin
            mn_in = rdata;
            if (cnt_ff == CW'(1)) begin
               tmp_in   = rdata;
               state_in = mmh_pkg::ST_OUT;
            end else begin
               re       = 1'b1;
               raddr    = IW'(1);
               state_in = mmh_pkg::ST_FIN2;
            end
         end
         mmh_pkg::ST_FIN2: begin
            tmp_in = rdata;
            if (cnt_ff == CW'(2)) begin
               state_in = mmh_pkg::ST_OUT;
            end else begin
               re       = 1'b1;
               raddr    = IW'(2);
               state_in = mmh_pkg::ST_FIN3;
            end
         end
         mmh_pkg::ST_FIN3: begin
            if (rdata > tmp_ff) begin
               tmp_in = rdata;
            end
            state_in = mmh_pkg::ST_OUT;
         end
         mmh_pkg::ST_OUT: begin
            if (!o_valid_ff || rsp_tready) begin
               o_valid_in = 1'b1;
               o_stat_in  = stat_ff;
               o_rem_in   = rem_ff;
               o_cnt_in   = cnt_ff;
               o_mn_in    = mn_ff;
               o_mx_in    = tmp_ff;
               state_in   = mmh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mmh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mmh_pkg::ST_IDLE;
         cnt_ff     <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      stat_ff      <= stat_in;
      key_ff       <= key_in;
      rem_ff       <= rem_in;
      c_ff         <= c_in;
      tmp_ff       <= tmp_in;
      best_ff      <= best_in;
      ch0_ff       <= ch0_in;
      ch1_ff       <= ch1_in;
      mn_ff        <= mn_in;
      w2_data_ff   <= w2_data_in;
      i_ff         <= i_in;
      orig_ff      <= orig_in;
      w2_addr_ff   <= w2_addr_in;
      w2_fin_ff    <= w2_fin_in;
      climb_min_ff <= climb_min_in;
      sink_min_ff  <= sink_min_in;
      scan_ff      <= scan_in;
      chk_ff       <= chk_in;
      chk_idx_ff   <= chk_idx_in;
      a_ff         <= a_in;
      k_ff         <= k_in;
      bk_ff        <= bk_in;
      o_stat_ff    <= o_stat_in;
      o_rem_ff     <= o_rem_in;
      o_cnt_ff     <= o_cnt_in;
      o_mn_ff      <= o_mn_in;
      o_mx_ff      <= o_mx_in;
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = RW'({32'(o_mx_ff), 32'(o_mn_ff), o_cnt_ff, 32'(o_rem_ff), o_stat_ff});

   // no read of an entry in the cycle it is written
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(we && re && waddr == raddr))
      else $error("heap ram read and write hit the same entry");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != $past(cnt_ff) |->
         (cnt_ff == $past(cnt_ff) + CW'(1) || cnt_ff == $past(cnt_ff) - CW'(1)))
      else $error("entry count moved by more than one");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff && o_stat_ff == mmh_pkg::STAT_FULL |-> o_cnt_ff == CW'(CAPACITY))
      else $error("full status with room left");

   a_one_op_per_count_change: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != mmh_pkg::ST_IDLE)
      else $error("accepted word left no work");

endmodule
`default_nettype wire
